@@ rtl/connection_slot_admission_defines.svh @@
// Assertion macros for the slot admission block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CONNECTION_SLOT_ADMISSION_DEFINES_SVH
`define CONNECTION_SLOT_ADMISSION_DEFINES_SVH

`ifndef SYNTHESIS
// Check an expression at every clock edge outside reset.
`define CSA_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Check a consequence on the clock after its trigger.
`define CSA_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);
`else
`define CSA_ASSERT(lbl, expr, msg)
`define CSA_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

@@ rtl/csa_pkg.sv @@
`timescale 1ns / 1ps
package csa_pkg;

	localparam int ID_W  = 8;
	localparam int FLG_W = 3;
	localparam int LIM_W = 6;

	localparam int RUNNING_DEPTH_DEF = 32;
	localparam int WAITING_DEPTH_DEF = 32;

	localparam logic [LIM_W-1:0] MAX_RESULTS = 6'd32;
	localparam logic [LIM_W-1:0] HARD_RESET  = 6'd32;
	localparam logic [LIM_W-1:0] SOFT_RESET  = 6'd16;

	// register indexes
	localparam logic REG_HARD = 1'b0;
	localparam logic REG_SOFT = 1'b1;

	// opcodes
	localparam logic [3:0] OP_ACCEPT   = 4'd0;
	localparam logic [3:0] OP_CONNECT  = 4'd1;
	localparam logic [3:0] OP_ADD      = 4'd2;
	localparam logic [3:0] OP_SWITCH   = 4'd3;
	localparam logic [3:0] OP_FREED    = 4'd4;
	localparam logic [3:0] OP_WITHDRAW = 4'd5;
	localparam logic [3:0] OP_STATUS   = 4'd6;
	localparam logic [3:0] OP_TICK     = 4'd7;
	localparam logic [3:0] OP_LIMITS   = 4'd8;

	// result kinds
	localparam logic [2:0] K_DONE     = 3'd0;
	localparam logic [2:0] K_GRANT    = 3'd1;
	localparam logic [2:0] K_REFUSED  = 3'd2;
	localparam logic [2:0] K_QUEUED   = 3'd3;
	localparam logic [2:0] K_PREEMPT  = 3'd4;
	localparam logic [2:0] K_NOVICTIM = 3'd5;
	localparam logic [2:0] K_DISARMED = 3'd6;

	typedef struct packed {
		logic [3:0]      opcode;
		logic [ID_W-1:0] conn_id;
		logic [ID_W-1:0] new_conn_id;
		logic            can_close;
		logic            buffers_empty;
		logic            has_queued;
	} csa_in_t;

	typedef struct packed {
		logic [2:0]       result_kind;
		logic [ID_W-1:0]  target_id;
		logic [LIM_W-1:0] slots_in_use;
		logic             timer_on;
		logic             last;
	} csa_out_t;

	// per-cell control: load own data, take neighbour data, move token, clear token
	typedef struct packed {
		logic ld;
		logic sh;
		logic adv;
		logic clr;
	} csa_cell_ctl_t;

endpackage

@@ rtl/csa_cell.sv @@
`timescale 1ns / 1ps
module csa_cell #(
	parameter int W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  csa_pkg::csa_cell_ctl_t ctl,
	input  logic [W-1:0]           wdata,
	input  logic [W-1:0]           nb_data,
	input  logic                   tok_in,
	output logic                   tok,
	output logic [W-1:0]           data
);
	import csa_pkg::*;

	logic [W-1:0] data_q;
	logic         tok_q;

	// hold entry, load a new one or take the right neighbour's
	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			data_q <= wdata;
		end else if (ctl.sh) begin
			data_q <= nb_data;
		end
	end

	// pass the scan token along the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.clr) begin
			tok_q <= 1'b0;
		end else if (ctl.adv) begin
			tok_q <= tok_in;
		end
	end

	assign tok  = tok_q;
	assign data = data_q;

endmodule

@@ rtl/connection_slot_admission.sv @@
`timescale 1ns / 1ps
// Slot admission: one input beat at a time, the next taken once the sequencer is idle.
// Accept, connect, add running, a tick that only disarms the timer and unknown opcodes
// are settled in the execute state. Switch, status, a preempting tick and withdraw walk
// a token along the running or waiting cell row, one cell per cycle while the output
// is not stalled, a withdraw that closes the gap included. A freed beat also closes the
// gap and then settles the slot. Limits changed then gives its results in turn, the
// last one flagged. Output stalls hold every step.
`include "connection_slot_admission_defines.svh"
module connection_slot_admission #(
	parameter int RUNNING_DEPTH = csa_pkg::RUNNING_DEPTH_DEF,
	parameter int WAITING_DEPTH = csa_pkg::WAITING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  csa_pkg::csa_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output csa_pkg::csa_out_t              out_data,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [csa_pkg::LIM_W-1:0]      cfg_data
);
	import csa_pkg::*;

	localparam int RCW = $clog2(RUNNING_DEPTH + 1);
	localparam int WCW = $clog2(WAITING_DEPTH + 1);
	localparam int RW  = FLG_W + ID_W;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_EXEC   = 8'b0000_0010,
		ST_SCANR  = 8'b0000_0100,
		ST_SHIFTR = 8'b0000_1000,
		ST_FREED  = 8'b0001_0000,
		ST_SCANW  = 8'b0010_0000,
		ST_SHIFTW = 8'b0100_0000,
		ST_LIMITS = 8'b1000_0000
	} st_t;

	st_t st_q, st_d;

	logic [3:0]       op_q;
	logic [ID_W-1:0]  id_q, nid_q;
	logic [FLG_W-1:0] flg_q;
	logic [LIM_W-1:0] hard_q, soft_q, used_q, used_d, n_q, n_d;
	logic             timer_q, timer_d;
	logic [RCW-1:0]   rcnt_q, rcnt_d, rk_q, rk_d;
	logic [WCW-1:0]   wcnt_q, wcnt_d, wk_q, wk_d;
	logic             sec_v_q, sec_v_d, thr_v_q, thr_v_d;
	logic [ID_W-1:0]  sec_id_q, sec_id_d, thr_id_q, thr_id_d;
	csa_out_t         out_q;
	logic             out_v_q;

	csa_cell_ctl_t    r_ctl [RUNNING_DEPTH];
	csa_cell_ctl_t    w_ctl [WAITING_DEPTH];
	logic [RW-1:0]    r_data [RUNNING_DEPTH];
	logic [ID_W-1:0]  w_data [WAITING_DEPTH];
	logic [RUNNING_DEPTH-1:0] r_tok;
	logic [WAITING_DEPTH-1:0] w_tok;
	logic [RW-1:0]    r_wd, r_cur;
	logic [ID_W-1:0]  w_cur;

	logic r_start, r_app, r_ld_tok, r_sh_tok, r_adv, r_clr;
	logic w_start, w_app, w_pop, w_sh_tok, w_adv, w_clr;
	logic free, emit, e_last;
	logic [2:0]      e_kind;
	logic [ID_W-1:0] e_tgt;
	logic [FLG_W-1:0] cf;
	logic            hit_r;

	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign free      = !out_v_q || !out_stall;

	// select the cell under the token
	always_comb begin
		r_cur = '0;
		for (int i = 0; i < RUNNING_DEPTH; i++) begin
			r_cur = r_cur | (r_data[i] & {RW{r_tok[i]}});
		end
		w_cur = '0;
		for (int i = 0; i < WAITING_DEPTH; i++) begin
			w_cur = w_cur | (w_data[i] & {ID_W{w_tok[i]}});
		end
	end

	assign cf    = r_cur[RW-1:ID_W];
	assign hit_r = (r_cur[ID_W-1:0] == id_q);

	// sequencer
	always_comb begin
		st_d     = st_q;
		used_d   = used_q;
		timer_d  = timer_q;
		rcnt_d   = rcnt_q;
		wcnt_d   = wcnt_q;
		rk_d     = rk_q;
		wk_d     = wk_q;
		n_d      = n_q;
		sec_v_d  = sec_v_q;
		thr_v_d  = thr_v_q;
		sec_id_d = sec_id_q;
		thr_id_d = thr_id_q;
		r_start  = 1'b0;
		r_app    = 1'b0;
		r_ld_tok = 1'b0;
		r_sh_tok = 1'b0;
		r_adv    = 1'b0;
		r_clr    = 1'b0;
		r_wd     = {{FLG_W{1'b0}}, id_q};
		w_start  = 1'b0;
		w_app    = 1'b0;
		w_pop    = 1'b0;
		w_sh_tok = 1'b0;
		w_adv    = 1'b0;
		w_clr    = 1'b0;
		emit     = 1'b0;
		e_last   = 1'b1;
		e_kind   = K_DONE;
		e_tgt    = id_q;

		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					st_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (free) begin
					st_d = ST_IDLE;
					case (op_q)
						OP_ACCEPT: begin
							emit = 1'b1;
							if (used_q < hard_q) begin
								used_d = used_q + 6'd1;
								if ((used_q + 6'd1) > soft_q) begin
									timer_d = 1'b1;
								end
								e_kind = K_GRANT;
							end else begin
								e_kind = K_REFUSED;
							end
						end
						OP_CONNECT: begin
							emit = 1'b1;
							if (used_q < soft_q) begin
								used_d = used_q + 6'd1;
								e_kind = K_GRANT;
							end else if (wcnt_q >= WCW'(WAITING_DEPTH)) begin
								e_kind = K_REFUSED;
							end else begin
								w_app   = 1'b1;
								wcnt_d  = wcnt_q + 1'b1;
								timer_d = 1'b1;
								e_kind  = K_QUEUED;
							end
						end
						OP_ADD: begin
							emit = 1'b1;
							if (rcnt_q >= RCW'(RUNNING_DEPTH)) begin
								e_kind = K_REFUSED;
							end else begin
								r_app  = 1'b1;
								rcnt_d = rcnt_q + 1'b1;
							end
						end
						OP_SWITCH, OP_FREED, OP_STATUS: begin
							r_start = 1'b1;
							r_adv   = 1'b1;
							rk_d    = '0;
							st_d    = ST_SCANR;
						end
						OP_TICK: begin
							if (used_q > soft_q || (used_q == soft_q && wcnt_q != '0)) begin
								r_start = 1'b1;
								r_adv   = 1'b1;
								rk_d    = '0;
								sec_v_d = 1'b0;
								thr_v_d = 1'b0;
								st_d    = ST_SCANR;
							end else begin
								emit    = 1'b1;
								timer_d = 1'b0;
								e_kind  = K_DISARMED;
								e_tgt   = '0;
							end
						end
						OP_WITHDRAW: begin
							w_start = 1'b1;
							w_adv   = 1'b1;
							wk_d    = '0;
							st_d    = ST_SCANW;
						end
						OP_LIMITS: begin
							if (used_q > soft_q) begin
								timer_d = 1'b1;
							end
							n_d  = '0;
							st_d = ST_LIMITS;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_SCANR: begin
				if (free) begin
					if (rk_q == rcnt_q) begin
						// walked past the last entry
						r_clr = 1'b1;
						st_d  = ST_IDLE;
						case (op_q)
							OP_SWITCH: begin
								emit   = 1'b1;
								e_kind = K_REFUSED;
								e_tgt  = nid_q;
							end
							OP_STATUS: begin
								emit   = 1'b1;
								e_kind = K_REFUSED;
							end
							OP_FREED: begin
								st_d = ST_FREED;
							end
							default: begin
								emit = 1'b1;
								if (sec_v_q) begin
									e_kind = K_PREEMPT;
									e_tgt  = sec_id_q;
								end else if (thr_v_q) begin
									e_kind = K_PREEMPT;
									e_tgt  = thr_id_q;
								end else begin
									e_kind = K_NOVICTIM;
									e_tgt  = '0;
								end
							end
						endcase
					end else begin
						case (op_q)
							OP_SWITCH: begin
								if (hit_r) begin
									r_ld_tok = 1'b1;
									r_wd     = {{FLG_W{1'b0}}, nid_q};
									r_clr    = 1'b1;
									emit     = 1'b1;
									e_tgt    = nid_q;
									st_d     = ST_IDLE;
								end else begin
									r_adv = 1'b1;
									rk_d  = rk_q + 1'b1;
								end
							end
							OP_STATUS: begin
								if (hit_r) begin
									r_ld_tok = 1'b1;
									r_wd     = {flg_q, id_q};
									r_clr    = 1'b1;
									emit     = 1'b1;
									st_d     = ST_IDLE;
								end else begin
									r_adv = 1'b1;
									rk_d  = rk_q + 1'b1;
								end
							end
							OP_FREED: begin
								if (hit_r) begin
									st_d = ST_SHIFTR;
								end else begin
									r_adv = 1'b1;
									rk_d  = rk_q + 1'b1;
								end
							end
							default: begin
								if (cf[0] && cf[1] && !cf[2]) begin
									r_clr  = 1'b1;
									emit   = 1'b1;
									e_kind = K_PREEMPT;
									e_tgt  = r_cur[ID_W-1:0];
									st_d   = ST_IDLE;
								end else begin
									if (cf[0] && cf[1] && !sec_v_q) begin
										sec_v_d  = 1'b1;
										sec_id_d = r_cur[ID_W-1:0];
									end
									if (cf[0] && !cf[1] && !thr_v_q) begin
										thr_v_d  = 1'b1;
										thr_id_d = r_cur[ID_W-1:0];
									end
									r_adv = 1'b1;
									rk_d  = rk_q + 1'b1;
								end
							end
						endcase
					end
				end
			end
			ST_SHIFTR: begin
				// close the gap one cell per cycle while the output is not stalled
				if (free) begin
					if ((rk_q + 1'b1) < rcnt_q) begin
						r_sh_tok = 1'b1;
						r_adv    = 1'b1;
						rk_d     = rk_q + 1'b1;
					end else begin
						r_clr  = 1'b1;
						rcnt_d = rcnt_q - 1'b1;
						st_d   = ST_FREED;
					end
				end
			end
			ST_FREED: begin
				if (free) begin
					emit = 1'b1;
					st_d = ST_IDLE;
					if (used_q <= soft_q && wcnt_q != '0) begin
						w_pop  = 1'b1;
						wcnt_d = wcnt_q - 1'b1;
						e_kind = K_GRANT;
						e_tgt  = w_data[0];
					end else if (used_q != '0) begin
						used_d = used_q - 6'd1;
					end
				end
			end
			ST_SCANW: begin
				if (free) begin
					if (wk_q == wcnt_q) begin
						w_clr = 1'b1;
						emit  = 1'b1;
						st_d  = ST_IDLE;
					end else if (w_cur == id_q) begin
						st_d = ST_SHIFTW;
					end else begin
						w_adv = 1'b1;
						wk_d  = wk_q + 1'b1;
					end
				end
			end
			ST_SHIFTW: begin
				if (free) begin
					if ((wk_q + 1'b1) < wcnt_q) begin
						w_sh_tok = 1'b1;
						w_adv    = 1'b1;
						wk_d     = wk_q + 1'b1;
					end else begin
						w_clr  = 1'b1;
						wcnt_d = wcnt_q - 1'b1;
						emit   = 1'b1;
						st_d   = ST_IDLE;
					end
				end
			end
			ST_LIMITS: begin
				// grant waiters one per cycle below the soft limit while the output is not stalled
				if (free) begin
					emit = 1'b1;
					if (used_q < soft_q) begin
						if (wcnt_q != '0) begin
							w_pop  = 1'b1;
							wcnt_d = wcnt_q - 1'b1;
							used_d = used_q + 6'd1;
							n_d    = n_q + 6'd1;
							e_kind = K_GRANT;
							e_tgt  = w_data[0];
							e_last = !(((used_q + 6'd1) < soft_q) && ((n_q + 6'd1) < MAX_RESULTS));
						end else begin
							timer_d = 1'b0;
							e_kind  = K_DISARMED;
							e_tgt   = '0;
						end
					end
					if (e_last) begin
						st_d = ST_IDLE;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// per-cell controls
	always_comb begin
		for (int i = 0; i < RUNNING_DEPTH; i++) begin
			r_ctl[i].ld  = (r_app && rcnt_q == RCW'(i)) || (r_ld_tok && r_tok[i]);
			r_ctl[i].sh  = r_sh_tok && r_tok[i];
			r_ctl[i].adv = r_adv;
			r_ctl[i].clr = r_clr;
		end
		for (int i = 0; i < WAITING_DEPTH; i++) begin
			w_ctl[i].ld  = w_app && wcnt_q == WCW'(i);
			w_ctl[i].sh  = w_pop || (w_sh_tok && w_tok[i]);
			w_ctl[i].adv = w_adv;
			w_ctl[i].clr = w_clr;
		end
	end

	// running list row
	for (genvar g = 0; g < RUNNING_DEPTH; g++) begin : g_run
		logic [RW-1:0] nb;
		logic          ti;
		if (g == RUNNING_DEPTH - 1) begin : g_end
			assign nb = '0;
		end else begin : g_mid
			assign nb = r_data[g+1];
		end
		if (g == 0) begin : g_first
			assign ti = r_start;
		end else begin : g_next
			assign ti = r_tok[g-1];
		end
		csa_cell #(.W(RW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (r_ctl[g]),
			.wdata  (r_wd),
			.nb_data(nb),
			.tok_in (ti),
			.tok    (r_tok[g]),
			.data   (r_data[g])
		);
	end

	// waiting list row
	for (genvar g = 0; g < WAITING_DEPTH; g++) begin : g_wait
		logic [ID_W-1:0] nb;
		logic            ti;
		if (g == WAITING_DEPTH - 1) begin : g_end
			assign nb = '0;
		end else begin : g_mid
			assign nb = w_data[g+1];
		end
		if (g == 0) begin : g_first
			assign ti = w_start;
		end else begin : g_next
			assign ti = w_tok[g-1];
		end
		csa_cell #(.W(ID_W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (w_ctl[g]),
			.wdata  (id_q),
			.nb_data(nb),
			.tok_in (ti),
			.tok    (w_tok[g]),
			.data   (w_data[g])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			used_q  <= '0;
			timer_q <= 1'b0;
			rcnt_q  <= '0;
			wcnt_q  <= '0;
			rk_q    <= '0;
			wk_q    <= '0;
			n_q     <= '0;
			sec_v_q <= 1'b0;
			thr_v_q <= 1'b0;
			hard_q  <= HARD_RESET;
			soft_q  <= SOFT_RESET;
			out_v_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			used_q  <= used_d;
			timer_q <= timer_d;
			rcnt_q  <= rcnt_d;
			wcnt_q  <= wcnt_d;
			rk_q    <= rk_d;
			wk_q    <= wk_d;
			n_q     <= n_d;
			sec_v_q <= sec_v_d;
			thr_v_q <= thr_v_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HARD: hard_q <= cfg_data;
					REG_SOFT: soft_q <= cfg_data;
					default:  hard_q <= hard_q;
				endcase
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// hold the input beat and the result beat
	always_ff @(posedge clk) begin
		sec_id_q <= sec_id_d;
		thr_id_q <= thr_id_d;
		if (in_valid && !in_stall) begin
			op_q  <= in_data.opcode;
			id_q  <= in_data.conn_id;
			nid_q <= in_data.new_conn_id;
			flg_q <= {in_data.has_queued, in_data.buffers_empty, in_data.can_close};
		end
		if (emit) begin
			out_q.result_kind  <= e_kind;
			out_q.target_id    <= e_tgt;
			out_q.slots_in_use <= used_d;
			out_q.timer_on     <= timer_d;
			out_q.last         <= e_last;
		end
	end

	`CSA_ASSERT(a_rcnt_bound, rcnt_q <= RCW'(RUNNING_DEPTH), "running count overflow")
	`CSA_ASSERT(a_wcnt_bound, wcnt_q <= WCW'(WAITING_DEPTH), "waiting count overflow")
	`CSA_ASSERT(a_rtok_one, $onehot0(r_tok), "several running tokens")
	`CSA_ASSERT(a_wtok_one, $onehot0(w_tok), "several waiting tokens")
	`CSA_ASSERT_NEXT(a_last_idle, emit && e_last, st_q == ST_IDLE, "busy after last result")

endmodule

@@ test/tb_connection_slot_admission.sv @@
`timescale 1ns / 1ps
module tb_connection_slot_admission;
	import csa_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	csa_in_t           in_data;
	logic              out_valid;
	logic              out_stall;
	csa_out_t          out_data;
	logic              cfg_we;
	logic              cfg_index;
	logic [LIM_W-1:0]  cfg_data;

	connection_slot_admission dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// slot pool mirror
	int               hard_lim;
	int               soft_lim;
	int               used;
	logic [ID_W-1:0]  run_ids [RUNNING_DEPTH_DEF];
	logic [FLG_W-1:0] run_flg [RUNNING_DEPTH_DEF];
	int               run_cnt;
	logic [ID_W-1:0]  wait_ids [WAITING_DEPTH_DEF];
	int               wait_cnt;
	logic             armed;

	csa_out_t pending_results[$];
	int       errors;
	int       idle_pct;
	int       stall_pct;
	int       hold_req;
	int       hold_seen;
	int       hold_left;
	int       burst_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// queue one outcome with the current pool state
	task automatic post(input logic [2:0] kind, input logic [ID_W-1:0] tgt);
		csa_out_t r;
		r.result_kind  = kind;
		r.target_id    = tgt;
		r.slots_in_use = used[LIM_W-1:0];
		r.timer_on     = armed;
		r.last         = 1'b0;
		pending_results.push_back(r);
	endtask

	function automatic int find_run(input logic [ID_W-1:0] id);
		for (int i = 0; i < run_cnt; i++)
			if (run_ids[i] == id) return i;
		return -1;
	endfunction

	function automatic logic [ID_W-1:0] pop_waiter();
		logic [ID_W-1:0] head;
		head = wait_ids[0];
		for (int j = 0; j + 1 < wait_cnt; j++) wait_ids[j] = wait_ids[j+1];
		wait_cnt--;
		return head;
	endfunction

	// work out every outcome of one accepted beat
	task automatic admit_item(input csa_in_t it);
		int n0, p, first, second, third, pick, cnt;
		n0 = pending_results.size();
		cnt = 0;
		case (it.opcode)
			OP_ACCEPT: begin
				if (used < hard_lim) begin
					used++;
					if (used > soft_lim) armed = 1'b1;
					post(K_GRANT, it.conn_id);
				end else post(K_REFUSED, it.conn_id);
			end
			OP_CONNECT: begin
				if (used < soft_lim) begin
					used++;
					post(K_GRANT, it.conn_id);
				end else if (wait_cnt >= WAITING_DEPTH_DEF) post(K_REFUSED, it.conn_id);
				else begin
					wait_ids[wait_cnt++] = it.conn_id;
					armed = 1'b1;
					post(K_QUEUED, it.conn_id);
				end
			end
			OP_ADD: begin
				if (run_cnt >= RUNNING_DEPTH_DEF) post(K_REFUSED, it.conn_id);
				else begin
					run_ids[run_cnt] = it.conn_id;
					run_flg[run_cnt] = '0;
					run_cnt++;
					post(K_DONE, it.conn_id);
				end
			end
			OP_SWITCH: begin
				p = find_run(it.conn_id);
				if (p < 0) post(K_REFUSED, it.new_conn_id);
				else begin
					run_ids[p] = it.new_conn_id;
					run_flg[p] = '0;
					post(K_DONE, it.new_conn_id);
				end
			end
			OP_FREED: begin
				p = find_run(it.conn_id);
				if (p >= 0) begin
					for (int i = p; i + 1 < run_cnt; i++) begin
						run_ids[i] = run_ids[i+1];
						run_flg[i] = run_flg[i+1];
					end
					run_cnt--;
				end
				if (used <= soft_lim && wait_cnt > 0) post(K_GRANT, pop_waiter());
				else begin
					if (used > 0) used--;
					post(K_DONE, it.conn_id);
				end
			end
			OP_WITHDRAW: begin
				for (int i = 0; i < wait_cnt; i++) begin
					if (wait_ids[i] == it.conn_id) begin
						for (int j = i; j + 1 < wait_cnt; j++) wait_ids[j] = wait_ids[j+1];
						wait_cnt--;
						break;
					end
				end
				post(K_DONE, it.conn_id);
			end
			OP_STATUS: begin
				p = find_run(it.conn_id);
				if (p < 0) post(K_REFUSED, it.conn_id);
				else begin
					run_flg[p] = {it.has_queued, it.buffers_empty, it.can_close};
					post(K_DONE, it.conn_id);
				end
			end
			OP_TICK: begin
				if (used > soft_lim || (used == soft_lim && wait_cnt > 0)) begin
					first = -1; second = -1; third = -1;
					// rank victims: idle and drained, then drained, then any closable
					for (int i = 0; i < run_cnt; i++) begin
						if (!run_flg[i][0]) continue;
						if (run_flg[i][1]) begin
							if (!run_flg[i][2]) begin
								first = i;
								break;
							end
							if (second < 0) second = i;
						end else if (third < 0) third = i;
					end
					pick = first >= 0 ? first : (second >= 0 ? second : third);
					if (pick >= 0) post(K_PREEMPT, run_ids[pick]);
					else post(K_NOVICTIM, '0);
				end else begin
					armed = 1'b0;
					post(K_DISARMED, '0);
				end
			end
			OP_LIMITS: begin
				if (used > soft_lim) armed = 1'b1;
				while (used < soft_lim && cnt < MAX_RESULTS) begin
					if (wait_cnt > 0) begin
						used++;
						post(K_GRANT, pop_waiter());
						cnt++;
					end else begin
						armed = 1'b0;
						post(K_DISARMED, '0);
						cnt++;
						break;
					end
				end
				if (cnt == 0) post(K_DONE, it.conn_id);
			end
			default: post(K_DONE, it.conn_id);
		endcase
		if (pending_results.size() > n0)
			pending_results[pending_results.size()-1].last = 1'b1;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r >= idle_pct) return 0;
		if (r < idle_pct / 8) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// offer one beat and hold it until taken
	task automatic send_item(input csa_in_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		admit_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[LIM_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HARD) hard_lim = val & 63;
		else soft_lim = val & 63;
		@(posedge clk);
	endtask

	function automatic csa_in_t make_item(input logic [3:0] op, input logic [7:0] id,
			input logic [7:0] nid, input logic [2:0] flg);
		csa_in_t it;
		it.opcode        = op;
		it.conn_id       = id;
		it.new_conn_id   = nid;
		it.can_close     = flg[0];
		it.buffers_empty = flg[1];
		it.has_queued    = flg[2];
		return it;
	endfunction

	function automatic logic [7:0] pick_id();
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 7));
	endfunction

	function automatic csa_in_t rand_item();
		int r;
		logic [3:0] op;
		r = $urandom_range(0, 99);
		if (r < 14) op = OP_ACCEPT;
		else if (r < 30) op = OP_CONNECT;
		else if (r < 42) op = OP_ADD;
		else if (r < 54) op = OP_FREED;
		else if (r < 68) op = OP_STATUS;
		else if (r < 80) op = OP_TICK;
		else if (r < 86) op = OP_SWITCH;
		else if (r < 92) op = OP_WITHDRAW;
		else if (r < 97) op = OP_LIMITS;
		else op = 4'($urandom_range(9, 15));
		return make_item(op, pick_id(), pick_id(), 3'($urandom_range(0, 7)));
	endfunction

	// every opcode, id extremes and the odd corners
	task automatic test_directed();
		send_item(make_item(OP_TICK, 8'h00, 8'h00, 3'b000));
		send_item(make_item(OP_FREED, 8'hff, 8'h00, 3'b000));
		send_item(make_item(OP_SWITCH, 8'h05, 8'hff, 3'b000));
		send_item(make_item(OP_STATUS, 8'h05, 8'h00, 3'b111));
		send_item(make_item(OP_WITHDRAW, 8'h09, 8'h00, 3'b000));
		send_item(make_item(OP_ADD, 8'hff, 8'h00, 3'b000));
		send_item(make_item(OP_ADD, 8'h00, 8'h00, 3'b000));
		send_item(make_item(OP_ADD, 8'h00, 8'h00, 3'b000));
		send_item(make_item(OP_STATUS, 8'h00, 8'hff, 3'b011));
		send_item(make_item(OP_STATUS, 8'hff, 8'h00, 3'b111));
		send_item(make_item(OP_SWITCH, 8'h00, 8'h7f, 3'b000));
		send_item(make_item(OP_ACCEPT, 8'hff, 8'h00, 3'b000));
		send_item(make_item(OP_CONNECT, 8'h80, 8'h00, 3'b000));
		send_item(make_item(OP_LIMITS, 8'h01, 8'h00, 3'b000));
		send_item(make_item(4'hf, 8'haa, 8'h55, 3'b111));
		send_item(make_item(4'h9, 8'h55, 8'haa, 3'b000));
		send_item(make_item(OP_FREED, 8'h7f, 8'h00, 3'b000));
		send_item(make_item(OP_FREED, 8'hff, 8'h00, 3'b000));
		send_item(make_item(OP_TICK, 8'h00, 8'h00, 3'b000));
	endtask

	// queue a full wait list, then release it in one limits change
	task automatic test_limits();
		write_reg(REG_SOFT, 0);
		write_reg(REG_HARD, 0);
		send_item(make_item(OP_ACCEPT, 8'h11, 8'h00, 3'b000));
		for (int i = 0; i < 34; i++) send_item(make_item(OP_CONNECT, 8'(i), 8'h00, 3'b000));
		for (int i = 0; i < 33; i++) send_item(make_item(OP_ADD, 8'(i), 8'h00, 3'b000));
		send_item(make_item(OP_STATUS, 8'd3, 8'h00, 3'b001));
		send_item(make_item(OP_TICK, 8'h00, 8'h00, 3'b000));
		send_item(make_item(OP_WITHDRAW, 8'd2, 8'h00, 3'b000));
		write_reg(REG_SOFT, 32);
		write_reg(REG_HARD, 32);
		send_item(make_item(OP_LIMITS, 8'h00, 8'h00, 3'b000));
		send_item(make_item(OP_LIMITS, 8'h00, 8'h00, 3'b000));
		for (int i = 0; i < 33; i++) send_item(make_item(OP_ACCEPT, 8'(i), 8'h00, 3'b000));
		send_item(make_item(OP_TICK, 8'h00, 8'h00, 3'b000));
		for (int i = 0; i < 34; i++) send_item(make_item(OP_FREED, 8'(i), 8'h00, 3'b000));
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure();
		idle_pct = 0;
		hold_req++;
		for (int i = 0; i < 40; i++) send_item(rand_item());
		idle_pct = 30;
	endtask

	task automatic test_random(input int count);
		int soft_set [6] = '{0, 4, 8, 16, 32, 2};
		int hard_set [6] = '{32, 8, 0, 20, 32, 12};
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_HARD, hard_set[ph]);
			write_reg(REG_SOFT, soft_set[ph]);
			idle_pct  = (ph == 3) ? 0 : 30;
			stall_pct = (ph == 3) ? 0 : 25;
			for (int i = 0; i < count / 6; i++) send_item(rand_item());
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= 1'b0;
		cfg_data  <= '0;
		hard_lim = 32; soft_lim = 16; used = 0;
		run_cnt = 0; wait_cnt = 0; armed = 1'b0;
		errors = 0; idle_pct = 30; stall_pct = 25; hold_req = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		test_backpressure();
		test_random(220);
		write_reg(REG_SOFT, 16);
		test_backpressure();
		drain();
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	// receiver stall: random short stalls, rare bursts, requested hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			hold_seen  <= 0;
			hold_left  <= 0;
			burst_left <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left <= burst_left - 1;
			out_stall  <= 1'b1;
		end else if (stall_pct > 0 && $urandom_range(0, 199) == 0) begin
			burst_left <= $urandom_range(15, 50);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	function automatic void report(input string fld, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch expected %0d actual %0d", $time, fld, exp_v, act_v);
			errors++;
		end
	endfunction

	// compare each result beat with the oldest outstanding outcome
	always @(posedge clk) begin
		csa_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h", $time, out_data);
				errors++;
			end else begin
				want = pending_results.pop_front();
				report("result_kind", want.result_kind, out_data.result_kind);
				report("target_id", want.target_id, out_data.target_id);
				report("slots_in_use", want.slots_in_use, out_data.slots_in_use);
				report("timer_on", want.timer_on, out_data.timer_on);
				report("last", want.last, out_data.last);
			end
		end
	end

endmodule

@@ connection_slot_admission.f @@
+incdir+rtl
rtl/csa_pkg.sv
rtl/csa_cell.sv
rtl/connection_slot_admission.sv
test/tb_connection_slot_admission.sv
